// ===== rtl/pidpsl_pkg.sv =====
// Shared widths, constants and types of the PID position/speed loop.
package pidpsl_pkg;

  localparam int POS_FRAC   = 4;
  localparam int GAIN_FRAC  = 12;
  localparam int PROD_SHIFT = POS_FRAC + GAIN_FRAC;

  localparam int POS_W   = 16;
  localparam int ERR_W   = 18;
  localparam int DIFF_W  = 19;
  localparam int INTEG_W = 16;
  localparam int GAIN_W  = 24;
  localparam int LIMIT_W = 15;
  localparam int DRIVE_W = 16;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_LOOP_MODE,
    REG_SETPOINT,
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_INTEGRAL_LIMIT
  } reg_idx_e;

  localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 24'sd81920;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 24'sd410;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 24'sd593920;
  localparam logic [LIMIT_W-1:0]       LIMIT_RST  = 15'd640;

  typedef struct packed {
    logic                      loop_mode;
    logic signed [POS_W-1:0]   setpoint;
    logic signed [GAIN_W-1:0]  gain_p;
    logic signed [GAIN_W-1:0]  gain_i;
    logic signed [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0]        integral_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [INTEG_W-1:0] integ;
  } err_word_t;

endpackage

// ===== rtl/pidpsl_err_stage.sv =====
// Error, error change and clamped integral for each accepted position word.
module pidpsl_err_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pidpsl_pkg::cfg_t              cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [15:0]            position_i,
  output logic                          word_valid_o,
  input  logic                          word_stall_i,
  output pidpsl_pkg::err_word_t         word_o
);
  import pidpsl_pkg::*;

  localparam logic [16:0] FRAC_MASK = 17'((1 << POS_FRAC) - 1);
  localparam logic [16:0] UNIT      = 17'(1 << POS_FRAC);

  logic signed [POS_W-1:0]   prev_pos_q;
  logic signed [ERR_W-1:0]   prev_err_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic                      valid_q;
  err_word_t                 word_q;

  logic                      en;
  logic                      accept;
  logic signed [16:0]        delta;
  logic signed [16:0]        delta_base;
  logic signed [16:0]        delta_t;
  logic signed [ERR_W-1:0]   err_pos;
  logic signed [ERR_W-1:0]   err_spd;
  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [18:0]        sum;
  logic signed [18:0]        lim_pos;
  logic signed [18:0]        lim_neg;
  logic signed [18:0]        clamped;

  assign en         = !valid_q || !word_stall_i;
  assign accept     = in_valid_i && en;
  assign in_stall_o = !en;

  always_comb begin
    delta      = {position_i[15], position_i} - {prev_pos_q[15], prev_pos_q};
    delta_base = delta & ~FRAC_MASK;
    if (delta[16] && ((delta & FRAC_MASK) != 17'd0)) begin
      delta_t = delta_base + UNIT;
    end else begin
      delta_t = delta_base;
    end
    err_pos = {{2{position_i[15]}}, position_i} - {{2{cfg_i.setpoint[15]}}, cfg_i.setpoint};
    err_spd = {delta_t[16], delta_t} - {{2{cfg_i.setpoint[15]}}, cfg_i.setpoint};
    err     = cfg_i.loop_mode ? err_spd : err_pos;
    diff    = {err[17], err} - {prev_err_q[17], prev_err_q};
    sum     = {{3{integ_q[15]}}, integ_q} + {err[17], err};
    lim_pos = {4'b0000, cfg_i.integral_limit};
    lim_neg = -lim_pos;
    if (sum < lim_neg) begin
      clamped = lim_neg;
    end else if (sum > lim_pos) begin
      clamped = lim_pos;
    end else begin
      clamped = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pos_q <= '0;
      prev_err_q <= '0;
      integ_q    <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (en) begin
        valid_q <= in_valid_i;
      end
      if (accept) begin
        prev_pos_q <= position_i;
        prev_err_q <= err;
        integ_q    <= clamped[INTEG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q.err   <= err;
      word_q.diff  <= diff;
      word_q.integ <= clamped[INTEG_W-1:0];
    end
  end

  assign word_valid_o = valid_q;
  assign word_o       = word_q;

endmodule

// ===== rtl/pidpsl_drive_pipe.sv =====
// Pipelined gain products, constant divisions and saturation of the drive value.
module pidpsl_drive_pipe (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pidpsl_pkg::cfg_t       cfg_i,
  input  logic                   word_valid_i,
  output logic                   word_stall_o,
  input  pidpsl_pkg::err_word_t  word_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [15:0]     drive_o,
  output logic                   saturated_o
);
  import pidpsl_pkg::*;

  localparam logic [41:0] P_BIAS  = 42'((1 << PROD_SHIFT) - 1);
  localparam logic [26:0] M100    = 27'd85899346;
  localparam logic [31:0] M10     = 32'd3435973837;
  localparam logic [30:0] U_OFS   = 31'd1342177280;
  localparam logic [28:0] F_OFS   = 29'd134217728;
  localparam logic signed [29:0] DRIVE_MAX = 30'sd32767;
  localparam logic signed [29:0] DRIVE_MIN = -30'sd32768;

  logic vb_q, vc_q, vd_q, ve_q, vo_q;
  logic en_b, en_c, en_d, en_e, en_o;

  logic signed [41:0] b_pd_q;
  logic signed [42:0] b_dd_q;
  logic signed [39:0] b_id_q;

  logic [25:0] c_m_q;
  logic        c_neg_q;
  logic [30:0] c_u_q;
  logic        c_rnz_q;

  logic [18:0] d_qp_q;
  logic [27:0] d_qu_q;
  logic        d_neg_q;
  logic [3:0]  d_ulow_q;
  logic        d_rnz_q;

  logic signed [19:0] e_p_q;
  logic signed [28:0] e_f_q;
  logic               e_nz_q;

  logic signed [15:0] drive_q;
  logic               sat_q;

  logic signed [41:0] pd_b;
  logic signed [25:0] pa;
  logic [25:0]        m;
  logic signed [43:0] id_x;
  logic signed [43:0] id10;
  logic signed [43:0] r_sum;
  logic signed [27:0] r_hi;
  logic [30:0]        u;
  logic [52:0]        prod_p;
  logic [62:0]        prod_u;
  logic signed [19:0] p_val;
  logic signed [28:0] f_val;
  logic [3:0]         q10;
  logic [3:0]         rem;
  logic signed [29:0] s_sum;
  logic signed [29:0] q_adj;
  logic signed [15:0] drive_d;
  logic               sat_d;

  assign en_o = !vo_q || !out_stall_i;
  assign en_e = !ve_q || en_o;
  assign en_d = !vd_q || en_e;
  assign en_c = !vc_q || en_d;
  assign en_b = !vb_q || en_c;
  assign word_stall_o = !en_b;

  always_comb begin
    pd_b  = b_pd_q + (b_pd_q[41] ? P_BIAS : 42'd0);
    pa    = pd_b[41:PROD_SHIFT];
    m     = pa[25] ? 26'(-pa) : pa;
    id_x  = {{4{b_id_q[39]}}, b_id_q};
    id10  = (id_x <<< 3) + (id_x <<< 1);
    r_sum = {b_dd_q[42], b_dd_q} + id10;
    r_hi  = r_sum[43:PROD_SHIFT];
    u     = {{3{r_hi[27]}}, r_hi} + U_OFS;
  end

  always_comb begin
    prod_p = 53'(c_m_q) * 53'(M100);
    prod_u = 63'(c_u_q) * 63'(M10);
  end

  always_comb begin
    p_val = d_neg_q ? -{1'b0, d_qp_q} : {1'b0, d_qp_q};
    f_val = {1'b0, d_qu_q} - F_OFS;
    q10   = {d_qu_q[0], 3'b000} + {d_qu_q[2:0], 1'b0};
    rem   = d_ulow_q - q10;
  end

  always_comb begin
    s_sum = {{10{e_p_q[19]}}, e_p_q} + {e_f_q[28], e_f_q};
    q_adj = s_sum + 30'(s_sum[29] && e_nz_q);
    if (q_adj > DRIVE_MAX) begin
      drive_d = DRIVE_MAX[15:0];
      sat_d   = 1'b1;
    end else if (q_adj < DRIVE_MIN) begin
      drive_d = DRIVE_MIN[15:0];
      sat_d   = 1'b1;
    end else begin
      drive_d = q_adj[15:0];
      sat_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en_b) begin
        vb_q <= word_valid_i;
      end
      if (en_c) begin
        vc_q <= vb_q;
      end
      if (en_d) begin
        vd_q <= vc_q;
      end
      if (en_e) begin
        ve_q <= vd_q;
      end
      if (en_o) begin
        vo_q <= ve_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      b_pd_q <= 42'(cfg_i.gain_p) * 42'(word_i.err);
      b_dd_q <= 43'(cfg_i.gain_d) * 43'(word_i.diff);
      b_id_q <= 40'(cfg_i.gain_i) * 40'(word_i.integ);
    end
    if (en_c) begin
      c_m_q   <= m;
      c_neg_q <= pa[25];
      c_u_q   <= u;
      c_rnz_q <= r_sum[PROD_SHIFT-1:0] != '0;
    end
    if (en_d) begin
      d_qp_q   <= prod_p[51:33];
      d_qu_q   <= prod_u[62:35];
      d_neg_q  <= c_neg_q;
      d_ulow_q <= c_u_q[3:0];
      d_rnz_q  <= c_rnz_q;
    end
    if (en_e) begin
      e_p_q  <= p_val;
      e_f_q  <= f_val;
      e_nz_q <= d_rnz_q || (rem != 4'd0);
    end
    if (en_o) begin
      drive_q <= drive_d;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o = vo_q;
  assign drive_o     = drive_q;
  assign saturated_o = sat_q;

endmodule

// ===== rtl/pid_position_or_speed_loop_unit.sv =====
// Top level of the PID position/speed loop: configuration registers and the pipeline.
//
// Each input word carries one position sample (signed Q12.4) and gives one
// output word: a drive value in whole units, saturated to 16 bits, with a
// flag when it was clipped. Both channels use valid and stall; a word moves
// at a clock edge where valid is high and stall is low.
// Configuration registers are written through cfg_we_i, cfg_index_i and cfg_data_i,
// one per cycle; the user must only write while no word is in flight (not enforced).
// The block has six register stages: the error stage, which also holds the
// loop state, then products, shift and offset, reciprocal products,
// term assembly and the output register. One word is taken in every cycle
// while the pipeline is not stalled.
// When the receiver stalls, results wait in the output register; words keep
// entering until every stage holds one, then in_stall_o rises.
// Reset clears the pipeline, the previous error, position and integral, and
// loads the default gains, setpoint and integral limit.
module pid_position_or_speed_loop_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pidpsl_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [pidpsl_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [15:0]             position_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [15:0]             drive_o,
  output logic                           saturated_o
);
  import pidpsl_pkg::*;

  cfg_t      cfg_q;
  err_word_t word;
  logic      word_valid;
  logic      word_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loop_mode      <= 1'b0;
      cfg_q.setpoint       <= '0;
      cfg_q.gain_p         <= GAIN_P_RST;
      cfg_q.gain_i         <= GAIN_I_RST;
      cfg_q.gain_d         <= GAIN_D_RST;
      cfg_q.integral_limit <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_LOOP_MODE:      cfg_q.loop_mode      <= cfg_data_i[0];
        REG_SETPOINT:       cfg_q.setpoint       <= cfg_data_i[POS_W-1:0];
        REG_GAIN_P:         cfg_q.gain_p         <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_I:         cfg_q.gain_i         <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_D:         cfg_q.gain_d         <= cfg_data_i[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data_i[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pidpsl_err_stage u_err_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .position_i   (position_i),
    .word_valid_o (word_valid),
    .word_stall_i (word_stall),
    .word_o       (word)
  );

  pidpsl_drive_pipe u_drive_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .word_valid_i (word_valid),
    .word_stall_o (word_stall),
    .word_i       (word),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .drive_o      (drive_o),
    .saturated_o  (saturated_o)
  );

endmodule

// ===== sim/tb_pid_position_or_speed_loop_unit.sv =====
// Self-checking testbench for the PID position/speed loop, predicting each drive word.
module tb_pid_position_or_speed_loop_unit;
  import pidpsl_pkg::*;

  localparam int IDLE_PCT    = 22;
  localparam int HOLD_CYCLES = 60;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_WORDS = 53;
  localparam int HOLD_PHASE  = 3;
  localparam int CALM_PHASE  = 6;
  localparam int N_REGS      = REG_INTEGRAL_LIMIT + 1;
  localparam int P_DIV       = 100;
  localparam int D_DIV       = 10;
  localparam int PRINT_CAP   = 40;

  localparam logic [IDX_W-1:0] IDX_SPARE_LO = IDX_W'(REG_INTEGRAL_LIMIT + 1);
  localparam logic [IDX_W-1:0] IDX_SPARE_HI = '1;

  localparam logic signed [POS_W-1:0] SPEED_OPEN [7] = '{40, 56, 48, 47, -32768, 32767, 32767};
  localparam logic signed [POS_W-1:0] POS_SWEEP [9] =
    '{0, 32767, 32767, 32767, -32768, -32768, -32768, -1, 1};
  localparam logic signed [POS_W-1:0] LOW_GAIN_SEQ [4] = '{32767, -32768, 0, 32767};
  localparam logic signed [POS_W-1:0] HIGH_GAIN_SEQ [4] = '{-32768, 32767, 0, -100};

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      saturated;
  } drive_word_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [IDX_W-1:0]          cfg_index_i = '0;
  logic [CFG_W-1:0]          cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic signed [POS_W-1:0]   position_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [DRIVE_W-1:0] drive_o;
  logic                      saturated_o;

  cfg_t                      regs;
  logic signed [ERR_W-1:0]   last_err;
  logic signed [INTEG_W-1:0] err_sum;
  logic signed [POS_W-1:0]   last_pos;

  logic signed [POS_W-1:0]   pend_positions [$];
  drive_word_t               drive_due [$];
  drive_word_t               want;
  int                        mismatches = 0;
  logic                      calm = 1'b0;
  logic                      burst_arm = 1'b0;
  logic                      hold_done = 1'b0;
  int                        hold_left = 0;

  pid_position_or_speed_loop_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o),
    .saturated_o (saturated_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic drive_word_t predict_drive(input logic signed [POS_W-1:0] pos);
    longint unit_q, scale, p, sp, gp, gi, gd, lim, err, diff, integ, p_term, num, q;
    drive_word_t w;
    unit_q = longint'(1) << POS_FRAC;
    scale  = longint'(1) << PROD_SHIFT;
    p   = pos;
    sp  = longint'($signed(regs.setpoint));
    gp  = longint'($signed(regs.gain_p));
    gi  = longint'($signed(regs.gain_i));
    gd  = longint'($signed(regs.gain_d));
    lim = longint'(regs.integral_limit);
    if (regs.loop_mode) begin
      err = ((p - longint'(last_pos)) / unit_q) * unit_q - sp;
    end else begin
      err = p - sp;
    end
    diff  = err - longint'(last_err);
    integ = longint'(err_sum) + err;
    if (integ < -lim) integ = -lim;
    if (integ > lim) integ = lim;
    p_term = ((gp * err) / scale) / P_DIV;
    num = p_term * D_DIV * scale + gd * diff + D_DIV * gi * integ;
    q = num / (D_DIV * scale);
    w.saturated = 1'b0;
    if (q > 32767) begin
      q = 32767;
      w.saturated = 1'b1;
    end
    if (q < -32768) begin
      q = -32768;
      w.saturated = 1'b1;
    end
    w.drive  = q[DRIVE_W-1:0];
    last_err = err[ERR_W-1:0];
    err_sum  = integ[INTEG_W-1:0];
    last_pos = pos;
    return w;
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_LOOP_MODE:      regs.loop_mode = val[0];
      REG_SETPOINT:       regs.setpoint = val[POS_W-1:0];
      REG_GAIN_P:         regs.gain_p = val[GAIN_W-1:0];
      REG_GAIN_I:         regs.gain_i = val[GAIN_W-1:0];
      REG_GAIN_D:         regs.gain_d = val[GAIN_W-1:0];
      REG_INTEGRAL_LIMIT: regs.integral_limit = val[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pend_positions.size() != 0 || in_valid_i || drive_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Sender: a word stays on the port unchanged until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      position_i <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pend_positions.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid_i <= 1'b1;
        position_i <= pend_positions.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the pipeline backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (burst_arm && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) drive_due.push_back(predict_drive(position_i));
      if (out_valid_o && !out_stall_i) begin
        if (drive_due.size() == 0) begin
          note_mismatch($sformatf("unexpected word: drive %0d", drive_o));
        end else begin
          want = drive_due.pop_front();
          if (drive_o !== want.drive) begin
            note_mismatch($sformatf("drive %0d, predicted %0d", drive_o, want.drive));
          end
          if (saturated_o !== want.saturated) begin
            note_mismatch($sformatf("saturated %b, predicted %b", saturated_o,
                                    want.saturated));
          end
        end
      end
    end
  end

  initial begin
    int                      r;
    int                      tmp;
    int                      walk;
    logic [CFG_W-1:0]        val;
    logic signed [POS_W-1:0] rnd_pos;

    regs = '{loop_mode: 1'b0, setpoint: '0, gain_p: GAIN_P_RST, gain_i: GAIN_I_RST,
             gain_d: GAIN_D_RST, integral_limit: LIMIT_RST};
    last_err = '0;
    err_sum  = '0;
    last_pos = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The first speed sample measures from position zero.
    write_reg(REG_LOOP_MODE, 24'd1);
    @(negedge clk_i);
    foreach (SPEED_OPEN[k]) pend_positions.push_back(SPEED_OPEN[k]);
    wait_drained();

    // Switching back to the position loop keeps the loop state.
    write_reg(REG_LOOP_MODE, 24'd0);
    @(negedge clk_i);
    foreach (POS_SWEEP[k]) pend_positions.push_back(POS_SWEEP[k]);
    wait_drained();

    write_reg(REG_SETPOINT, 24'h008000);
    write_reg(REG_GAIN_P, 24'h800000);
    write_reg(REG_GAIN_I, 24'h7FFFFF);
    write_reg(REG_GAIN_D, 24'h800000);
    write_reg(REG_INTEGRAL_LIMIT, 24'h007FFF);
    write_reg(IDX_SPARE_LO, 24'hFFFFFF);
    write_reg(IDX_SPARE_HI, 24'hFFFFFF);
    @(negedge clk_i);
    foreach (LOW_GAIN_SEQ[k]) pend_positions.push_back(LOW_GAIN_SEQ[k]);
    wait_drained();

    write_reg(REG_LOOP_MODE, 24'd1);
    write_reg(REG_SETPOINT, 24'h007FFF);
    write_reg(REG_GAIN_P, 24'h7FFFFF);
    write_reg(REG_GAIN_I, 24'h800000);
    write_reg(REG_GAIN_D, 24'h7FFFFF);
    write_reg(REG_INTEGRAL_LIMIT, 24'h000000);
    @(negedge clk_i);
    foreach (HIGH_GAIN_SEQ[k]) pend_positions.push_back(HIGH_GAIN_SEQ[k]);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      for (r = 0; r < N_REGS; r++) begin
        if ($urandom_range(1) == 1) begin
          case (r)
            REG_LOOP_MODE: val = CFG_W'($urandom_range(1));
            REG_SETPOINT: begin
              case ($urandom_range(3))
                0: tmp = $urandom;
                1: tmp = $urandom_range(800) - 400;
                2: tmp = 32767;
                default: tmp = -32768;
              endcase
              val = CFG_W'(tmp);
            end
            REG_GAIN_P, REG_GAIN_I, REG_GAIN_D: begin
              case ($urandom_range(4))
                0: tmp = $urandom;
                1: tmp = $urandom_range(1 << 19) - (1 << 18);
                2: tmp = 32'h007FFFFF;
                3: tmp = 32'hFF800000;
                default: tmp = $urandom_range(1 << 20);
              endcase
              val = CFG_W'(tmp);
            end
            default: begin
              case ($urandom_range(3))
                0: val = CFG_W'($urandom);
                1: val = '0;
                2: val = 24'h007FFF;
                default: val = CFG_W'($urandom_range(1000));
              endcase
            end
          endcase
          write_reg(IDX_W'(r), val);
        end
      end
      if ($urandom_range(3) == 0) begin
        write_reg(IDX_W'($urandom_range(IDX_SPARE_HI, IDX_SPARE_LO)), CFG_W'($urandom));
      end
      @(negedge clk_i);
      calm = (ph == CALM_PHASE);
      if (ph == HOLD_PHASE) burst_arm = 1'b1;
      rnd_pos = POS_W'($urandom);
      walk = int'(rnd_pos);
      // Mostly a slowly moving axis, with jumps and end stops mixed in.
      for (int k = 0; k < PHASE_WORDS; k++) begin
        tmp = $urandom_range(99);
        if (tmp < 60) begin
          tmp = $urandom_range(600);
          walk = walk + tmp - 300;
          if (walk > 32767) walk = 32767;
          if (walk < -32768) walk = -32768;
        end else if (tmp < 85) begin
          rnd_pos = POS_W'($urandom);
          walk = int'(rnd_pos);
        end else begin
          case ($urandom_range(2))
            0: walk = 32767;
            1: walk = -32768;
            default: walk = 0;
          endcase
        end
        pend_positions.push_back(walk[POS_W-1:0]);
      end
    end

    wait_drained();
    calm = 1'b0;
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && drive_due.size() == 0) begin
      $display("pid_position_or_speed_loop_unit: match");
    end else begin
      $display("pid_position_or_speed_loop_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("pid_position_or_speed_loop_unit: mismatch");
    $finish;
  end

endmodule
